// ----- hw/rtl/lfu_pkg.sv -----
// Shared types and constants for the LFU cache.
`timescale 1ns / 1ps
`default_nettype none
package lfu_pkg;
    localparam int KEY_W   = 32;
    localparam int DATA_W  = 32;
    localparam int STAMP_W = 48;
    localparam int CFG_W   = 5;

    localparam logic [CFG_W-1:0] CAP_RESET = 5'd16;

    localparam logic OP_GET = 1'b0;
    localparam logic OP_PUT = 1'b1;

    typedef struct packed {
        logic clear;
        logic sample;
    } t_scan_ctl;
endpackage
`default_nettype wire

// ----- hw/rtl/lfu_store.sv -----
// Entry memory: key, data, use count and stamp, one write and one registered read port.
`timescale 1ns / 1ps
`default_nettype none
module lfu_store #(
    parameter int ENTRIES    = 16,
    parameter int COUNT_BITS = 32,
    localparam int ADDR_W    = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_wr_en,
    input  wire logic [ADDR_W-1:0]           i_wr_addr,
    input  wire logic [lfu_pkg::KEY_W-1:0]   i_wr_key,
    input  wire logic [lfu_pkg::DATA_W-1:0]  i_wr_data,
    input  wire logic [COUNT_BITS-1:0]       i_wr_count,
    input  wire logic [lfu_pkg::STAMP_W-1:0] i_wr_stamp,
    input  wire logic                        i_rd_en,
    input  wire logic [ADDR_W-1:0]           i_rd_addr,
    output logic      [lfu_pkg::KEY_W-1:0]   o_rd_key,
    output logic      [lfu_pkg::DATA_W-1:0]  o_rd_data,
    output logic      [COUNT_BITS-1:0]       o_rd_count,
    output logic      [lfu_pkg::STAMP_W-1:0] o_rd_stamp
);
    import lfu_pkg::*;

    logic [KEY_W-1:0]      r_key   [ENTRIES];
    logic [DATA_W-1:0]     r_data  [ENTRIES];
    logic [COUNT_BITS-1:0] r_count [ENTRIES];
    logic [STAMP_W-1:0]    r_stamp [ENTRIES];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_key[i_wr_addr]   <= i_wr_key;
            r_data[i_wr_addr]  <= i_wr_data;
            r_count[i_wr_addr] <= i_wr_count;
            r_stamp[i_wr_addr] <= i_wr_stamp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rd_key   <= r_key[i_rd_addr];
            o_rd_data  <= r_data[i_rd_addr];
            o_rd_count <= r_count[i_rd_addr];
            o_rd_stamp <= r_stamp[i_rd_addr];
        end
    end
endmodule
`default_nettype wire

// ----- hw/rtl/lfu_scan.sv -----
// Shared compare unit: key match and least-count, oldest-stamp victim tracking.
`timescale 1ns / 1ps
`default_nettype none
module lfu_scan #(
    parameter int ENTRIES    = 16,
    parameter int COUNT_BITS = 32,
    localparam int ADDR_W    = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire lfu_pkg::t_scan_ctl          i_ctl,
    input  wire logic [lfu_pkg::KEY_W-1:0]   i_key,
    input  wire logic [ADDR_W-1:0]           i_idx,
    input  wire logic [lfu_pkg::KEY_W-1:0]   i_ent_key,
    input  wire logic [lfu_pkg::DATA_W-1:0]  i_ent_data,
    input  wire logic [COUNT_BITS-1:0]       i_ent_count,
    input  wire logic [lfu_pkg::STAMP_W-1:0] i_ent_stamp,
    output logic                             o_found,
    output logic      [ADDR_W-1:0]           o_found_idx,
    output logic      [lfu_pkg::DATA_W-1:0]  o_found_data,
    output logic      [COUNT_BITS-1:0]       o_found_count,
    output logic      [ADDR_W-1:0]           o_vic_idx,
    output logic      [lfu_pkg::KEY_W-1:0]   o_vic_key
);
    import lfu_pkg::*;

    logic                  r_have_vic;
    logic [COUNT_BITS-1:0] r_vic_count;
    logic [STAMP_W-1:0]    r_vic_stamp;
    logic                  match;
    logic                  older;

    assign match = !o_found && (i_ent_key == i_key);
    assign older = !r_have_vic || (i_ent_count < r_vic_count) ||
                   ((i_ent_count == r_vic_count) && (i_ent_stamp < r_vic_stamp));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_found    <= 1'b0;
            r_have_vic <= 1'b0;
        end else if (i_ctl.clear) begin
            o_found    <= 1'b0;
            r_have_vic <= 1'b0;
        end else if (i_ctl.sample) begin
            if (match) begin
                o_found <= 1'b1;
            end
            if (older) begin
                r_have_vic <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.sample && !i_ctl.clear) begin
            if (match) begin
                o_found_idx   <= i_idx;
                o_found_data  <= i_ent_data;
                o_found_count <= i_ent_count;
            end
            if (older) begin
                o_vic_idx   <= i_idx;
                o_vic_key   <= i_ent_key;
                r_vic_count <= i_ent_count;
                r_vic_stamp <= i_ent_stamp;
            end
        end
    end
endmodule
`default_nettype wire

// ----- hw/rtl/lfu_cache_lru_tiebreak.sv -----
// LFU cache top level: sequencer, occupancy, use clock and result registers.
// Steps: S_IDLE accepts the start transfer, S_SCAN reads the occupied slots and
// S_WB updates the entry and registers o_valid; a new transfer is taken only in S_IDLE.
// The single memory read port scans one occupied slot per cycle.
// The result is shown for one cycle only; the receiver cannot stall it.
// Reset (synchronous, active low) empties the cache and sets capacity to 16.
`timescale 1ns / 1ps
`default_nettype none
module lfu_cache_lru_tiebreak #(
    parameter int ENTRIES    = 16,
    parameter int COUNT_BITS = 32
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        start,
    output logic                             busy,
    input  wire logic                        i_operation,
    input  wire logic [lfu_pkg::KEY_W-1:0]   i_key,
    input  wire logic [lfu_pkg::DATA_W-1:0]  i_value,
    output logic                             o_valid,
    output logic                             o_hit,
    output logic      [lfu_pkg::DATA_W-1:0]  o_read_value,
    output logic                             o_evicted,
    output logic      [lfu_pkg::KEY_W-1:0]   o_evicted_key,
    input  wire logic                        i_cfg_valid,
    output logic                             o_cfg_ready,
    input  wire logic [lfu_pkg::CFG_W-1:0]   i_cfg_data
);
    import lfu_pkg::*;

    localparam int ADDR_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int OCC_W  = $clog2(ENTRIES + 1);
    localparam int CMP_W  = (OCC_W > CFG_W) ? OCC_W : CFG_W;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_WB
    } t_state;

    t_state             r_state;
    logic [CFG_W-1:0]   r_cap;
    logic [OCC_W-1:0]   r_occ;
    logic [OCC_W-1:0]   r_addr;
    logic               r_pend;
    logic [ADDR_W-1:0]  r_sidx;
    logic [STAMP_W-1:0] r_clock;
    logic               r_op;
    logic [KEY_W-1:0]   r_key;
    logic [DATA_W-1:0]  r_val;

    logic                  accept;
    logic                  issue;
    logic                  full;
    t_scan_ctl             scan_ctl;
    logic                  found;
    logic [ADDR_W-1:0]     found_idx;
    logic [DATA_W-1:0]     found_data;
    logic [COUNT_BITS-1:0] found_count;
    logic [ADDR_W-1:0]     vic_idx;
    logic [KEY_W-1:0]      vic_key;
    logic [KEY_W-1:0]      rd_key;
    logic [DATA_W-1:0]     rd_data;
    logic [COUNT_BITS-1:0] rd_count;
    logic [STAMP_W-1:0]    rd_stamp;
    logic                  wr_en;
    logic [ADDR_W-1:0]     wr_addr;
    logic [DATA_W-1:0]     wr_data;
    logic [COUNT_BITS-1:0] wr_count;

    assign busy        = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign accept      = start && !busy;
    assign issue       = (r_state == S_SCAN) && (r_addr != r_occ);

    assign scan_ctl.clear  = accept;
    assign scan_ctl.sample = r_pend;

    // evict when occupancy reaches the clamped capacity (zero acts as one)
    assign full = (r_occ == OCC_W'(ENTRIES)) ||
                  ((r_occ != '0) && (CMP_W'(r_occ) >= CMP_W'(r_cap)));

    always_comb begin
        wr_en    = 1'b0;
        wr_addr  = r_occ[ADDR_W-1:0];
        wr_data  = r_val;
        wr_count = COUNT_BITS'(1);
        if (r_state == S_WB) begin
            if (found) begin
                wr_en   = 1'b1;
                wr_addr = found_idx;
                if (r_op == OP_GET) begin
                    wr_data = found_data;
                end
                if (found_count == '1) begin
                    wr_count = found_count;
                end else begin
                    wr_count = found_count + COUNT_BITS'(1);
                end
            end else if (r_op == OP_PUT) begin
                wr_en = 1'b1;
                if (full) begin
                    wr_addr = vic_idx;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cap   <= CAP_RESET;
            r_occ   <= '0;
            r_clock <= '0;
            r_pend  <= 1'b0;
            o_valid <= 1'b0;
        end else begin
            o_valid <= 1'b0;
            if (i_cfg_valid && o_cfg_ready) begin
                r_cap <= i_cfg_data;
            end
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_op    <= i_operation;
                        r_key   <= i_key;
                        r_val   <= i_value;
                        r_addr  <= '0;
                        r_state <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    r_pend <= issue;
                    r_sidx <= r_addr[ADDR_W-1:0];
                    if (issue) begin
                        r_addr <= r_addr + OCC_W'(1);
                    end else begin
                        r_state <= S_WB;
                    end
                end
                S_WB: begin
                    r_pend        <= 1'b0;
                    o_valid       <= 1'b1;
                    o_hit         <= found;
                    o_read_value  <= '0;
                    o_evicted     <= 1'b0;
                    o_evicted_key <= '0;
                    if (found) begin
                        r_clock <= r_clock + STAMP_W'(1);
                        if (r_op == OP_GET) begin
                            o_read_value <= found_data;
                        end
                    end else if (r_op == OP_PUT) begin
                        r_clock <= r_clock + STAMP_W'(1);
                        if (full) begin
                            o_evicted     <= 1'b1;
                            o_evicted_key <= vic_key;
                        end else begin
                            r_occ <= r_occ + OCC_W'(1);
                        end
                    end
                    r_state <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    lfu_store #(
        .ENTRIES    (ENTRIES),
        .COUNT_BITS (COUNT_BITS)
    ) u_store (
        .i_clk      (i_clk),
        .i_wr_en    (wr_en),
        .i_wr_addr  (wr_addr),
        .i_wr_key   (r_key),
        .i_wr_data  (wr_data),
        .i_wr_count (wr_count),
        .i_wr_stamp (r_clock),
        .i_rd_en    (issue),
        .i_rd_addr  (r_addr[ADDR_W-1:0]),
        .o_rd_key   (rd_key),
        .o_rd_data  (rd_data),
        .o_rd_count (rd_count),
        .o_rd_stamp (rd_stamp)
    );

    lfu_scan #(
        .ENTRIES    (ENTRIES),
        .COUNT_BITS (COUNT_BITS)
    ) u_scan (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_ctl         (scan_ctl),
        .i_key         (r_key),
        .i_idx         (r_sidx),
        .i_ent_key     (rd_key),
        .i_ent_data    (rd_data),
        .i_ent_count   (rd_count),
        .i_ent_stamp   (rd_stamp),
        .o_found       (found),
        .o_found_idx   (found_idx),
        .o_found_data  (found_data),
        .o_found_count (found_count),
        .o_vic_idx     (vic_idx),
        .o_vic_key     (vic_key)
    );
endmodule
`default_nettype wire

// ----- dv/tb_top.sv -----
// Self-checking testbench for the LFU cache with LRU tie break.
`timescale 1ns / 1ps
module tb_top;
    import lfu_pkg::*;

    localparam int ENTRIES      = 16;
    localparam int LIMIT_CYCLES = 400000;
    localparam int END_SETTLE   = 24;

    typedef enum logic [1:0] {
        STEP_ACCESS,
        STEP_DRAIN,
        STEP_CAPACITY
    } t_step_kind;

    typedef struct {
        t_step_kind          kind;
        logic                op;
        logic [KEY_W-1:0]    key;
        logic [DATA_W-1:0]   value;
        logic [CFG_W-1:0]    cap;
    } t_cache_step;

    typedef struct packed {
        logic                hit;
        logic [DATA_W-1:0]   read_value;
        logic                evicted;
        logic [KEY_W-1:0]    evicted_key;
    } t_cache_result;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                start = 1'b0;
    logic                busy;
    logic                i_operation = OP_GET;
    logic [KEY_W-1:0]    i_key = '0;
    logic [DATA_W-1:0]   i_value = '0;
    logic                o_valid;
    logic                o_hit;
    logic [DATA_W-1:0]   o_read_value;
    logic                o_evicted;
    logic [KEY_W-1:0]    o_evicted_key;
    logic                i_cfg_valid = 1'b0;
    logic                o_cfg_ready;
    logic [CFG_W-1:0]    i_cfg_data = '0;

    lfu_cache_lru_tiebreak dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_operation   (i_operation),
        .i_key         (i_key),
        .i_value       (i_value),
        .o_valid       (o_valid),
        .o_hit         (o_hit),
        .o_read_value  (o_read_value),
        .o_evicted     (o_evicted),
        .o_evicted_key (o_evicted_key),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // cache shadow
    logic                line_valid [ENTRIES];
    logic [KEY_W-1:0]    line_key   [ENTRIES];
    logic [DATA_W-1:0]   line_data  [ENTRIES];
    logic [31:0]         line_count [ENTRIES];
    logic [STAMP_W-1:0]  line_stamp [ENTRIES];
    logic [STAMP_W-1:0]  use_clock = '0;
    int                  fill_level = 0;
    logic [CFG_W-1:0]    capacity_reg = CAP_RESET;

    t_cache_step         step_queue [$];
    t_cache_result       expected_results [$];

    int items_sent = 0;
    int items_accepted = 0;
    int cfg_sent = 0;
    int cfg_writes = 0;
    int results_seen = 0;
    int hits_seen = 0;
    int evictions_seen = 0;
    int mismatches = 0;
    int cycle_count = 0;
    int burst_left = 1;
    int gap_left = 0;

    initial begin
        for (int i = 0; i < ENTRIES; i++) begin
            line_valid[i] = 1'b0;
            line_key[i]   = '0;
            line_data[i]  = '0;
            line_count[i] = '0;
            line_stamp[i] = '0;
        end
    end

    function automatic t_cache_result predict_access(logic op, logic [KEY_W-1:0] k,
                                                     logic [DATA_W-1:0] v);
        t_cache_result r;
        int found, free_slot, victim, slot, cap;
        bit hit, have_free, have_victim;
        r = '0;
        found = 0;
        free_slot = 0;
        victim = 0;
        hit = 0;
        have_free = 0;
        have_victim = 0;
        for (int i = 0; i < ENTRIES; i++) begin
            if (!line_valid[i]) begin
                if (!have_free) begin
                    have_free = 1;
                    free_slot = i;
                end
            end else begin
                if (!hit && line_key[i] == k) begin
                    hit = 1;
                    found = i;
                end
                if (!have_victim || line_count[i] < line_count[victim] ||
                    (line_count[i] == line_count[victim] &&
                     line_stamp[i] < line_stamp[victim])) begin
                    have_victim = 1;
                    victim = i;
                end
            end
        end
        if (hit) begin
            r.hit = 1'b1;
            if (op == OP_GET)
                r.read_value = line_data[found];
            else
                line_data[found] = v;
            if (line_count[found] != '1)
                line_count[found] = line_count[found] + 32'd1;
            line_stamp[found] = use_clock;
            use_clock = use_clock + STAMP_W'(1);
            return r;
        end
        if (op == OP_GET)
            return r;
        cap = capacity_reg;
        if (cap == 0)
            cap = 1;
        if (cap > ENTRIES)
            cap = ENTRIES;
        if ((fill_level >= cap || !have_free) && have_victim) begin
            r.evicted = 1'b1;
            r.evicted_key = line_key[victim];
            slot = victim;
        end else if (have_free) begin
            slot = free_slot;
            fill_level++;
        end else begin
            return r;
        end
        line_valid[slot] = 1'b1;
        line_key[slot]   = k;
        line_data[slot]  = v;
        line_count[slot] = 32'd1;
        line_stamp[slot] = use_clock;
        use_clock = use_clock + STAMP_W'(1);
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("MISMATCH %s: got %h, want %h (result %0d, t=%0t)",
                 what, got, want, results_seen, $time);
        mismatches++;
    endtask

    task automatic add_access(logic op, logic [KEY_W-1:0] k, logic [DATA_W-1:0] v);
        t_cache_step s;
        s.kind = STEP_ACCESS;
        s.op = op;
        s.key = k;
        s.value = v;
        s.cap = '0;
        step_queue.push_back(s);
    endtask

    task automatic add_drain();
        t_cache_step s;
        s.kind = STEP_DRAIN;
        s.op = OP_GET;
        s.key = '0;
        s.value = '0;
        s.cap = '0;
        step_queue.push_back(s);
    endtask

    task automatic add_capacity(logic [CFG_W-1:0] c);
        t_cache_step s;
        add_drain();
        s.kind = STEP_CAPACITY;
        s.op = OP_GET;
        s.key = '0;
        s.value = '0;
        s.cap = c;
        step_queue.push_back(s);
    endtask

    // driver: bursts of transfers with random gaps, config only when drained
    always @(negedge i_clk) begin
        t_cache_step s;
        logic nxt_start, nxt_cfg;
        nxt_start = start;
        nxt_cfg = i_cfg_valid;
        if (!i_rst_n) begin
            nxt_start = 1'b0;
            nxt_cfg = 1'b0;
        end else begin
            if (start && items_accepted == items_sent)
                nxt_start = 1'b0;
            if (i_cfg_valid && cfg_writes == cfg_sent)
                nxt_cfg = 1'b0;
            if (!nxt_start && !nxt_cfg) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (step_queue.size() > 0) begin
                    s = step_queue[0];
                    if (s.kind == STEP_ACCESS) begin
                        void'(step_queue.pop_front());
                        nxt_start = 1'b1;
                        i_operation <= s.op;
                        i_key <= s.key;
                        i_value <= s.value;
                        items_sent++;
                        if (burst_left <= 1) begin
                            burst_left = $urandom_range(1, 24);
                            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 20);
                        end else begin
                            burst_left--;
                        end
                    end else if (expected_results.size() == 0 &&
                                 items_accepted == items_sent && !busy) begin
                        void'(step_queue.pop_front());
                        if (s.kind == STEP_CAPACITY) begin
                            nxt_cfg = 1'b1;
                            i_cfg_data <= s.cap;
                            cfg_sent++;
                        end
                    end
                end
            end
        end
        start <= nxt_start;
        i_cfg_valid <= nxt_cfg;
    end

    // monitor: check results, then record accepted transfers
    always @(posedge i_clk) begin
        t_cache_result want;
        if (i_rst_n) begin
            if (o_valid) begin
                results_seen++;
                if (o_hit)
                    hits_seen++;
                if (o_evicted)
                    evictions_seen++;
                if (expected_results.size() == 0) begin
                    report_mismatch("unexpected result key", o_evicted_key, '0);
                end else begin
                    want = expected_results.pop_front();
                    if (o_hit !== want.hit)
                        report_mismatch("hit", o_hit, want.hit);
                    if (o_read_value !== want.read_value)
                        report_mismatch("read_value", o_read_value, want.read_value);
                    if (o_evicted !== want.evicted)
                        report_mismatch("evicted", o_evicted, want.evicted);
                    if (o_evicted_key !== want.evicted_key)
                        report_mismatch("evicted_key", o_evicted_key, want.evicted_key);
                end
            end
            if (start && !busy) begin
                expected_results.push_back(predict_access(i_operation, i_key, i_value));
                items_accepted++;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                capacity_reg = i_cfg_data;
                cfg_writes++;
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("timeout after %0d cycles, %0d results pending",
                     cycle_count, expected_results.size());
            $display("tb_top: errors");
            $finish;
        end
    end

    initial begin
        logic [KEY_W-1:0] pool [$];
        int phase_caps [$];
        int per_phase, pool_size, idx;
        logic op;
        logic [KEY_W-1:0] k;

        // directed
        add_access(OP_GET, 32'h0000_0000, 32'h1111_1111);
        add_access(OP_PUT, 32'h0000_0000, 32'hFFFF_FFFF);
        add_access(OP_PUT, 32'hFFFF_FFFF, 32'h0000_0000);
        add_access(OP_GET, 32'h0000_0000, 32'h0);
        add_access(OP_GET, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        add_access(OP_PUT, 32'h0000_0000, 32'h1234_5678);
        add_access(OP_GET, 32'h0000_0000, 32'h0);
        add_access(OP_GET, 32'h5A5A_5A5A, 32'h0);
        add_access(OP_PUT, 32'h0000_0001, 32'hA5A5_A5A5);
        add_access(OP_PUT, 32'h0000_0002, 32'h5A5A_5A5A);
        // capacity dropped below fill level
        add_capacity(5'd1);
        add_access(OP_PUT, 32'h8000_0000, 32'h0000_0001);
        add_access(OP_PUT, 32'h7FFF_FFFF, 32'h8000_0000);
        add_access(OP_GET, 32'h0000_0001, 32'h0);
        add_access(OP_PUT, 32'h0000_0000, 32'hDEAD_BEEF);
        add_capacity(5'd0);
        add_access(OP_PUT, 32'h0000_0003, 32'hCAFE_F00D);
        add_access(OP_GET, 32'h0000_0003, 32'h0);
        add_capacity(5'd31);
        add_access(OP_PUT, 32'h0000_0004, 32'h0F0F_0F0F);
        add_access(OP_PUT, 32'h0000_0005, 32'hF0F0_F0F0);
        add_access(OP_GET, 32'h0000_0004, 32'h0);
        add_access(OP_GET, 32'hFFFF_FFFF, 32'h0);

        // random phases
        phase_caps = '{16, 1, 2, 0, 31, 8, 3, 16, 17, 5, 12, 1, 16};
        for (int n = 0; n < 3; n++)
            phase_caps.push_back($urandom_range(0, 31));
        per_phase = 950 / phase_caps.size();
        foreach (phase_caps[p]) begin
            add_capacity(CFG_W'(phase_caps[p]));
            pool.delete();
            pool_size = $urandom_range(2, 24);
            for (int n = 0; n < pool_size; n++)
                pool.push_back($urandom);
            if ($urandom_range(0, 3) == 0)
                pool.push_back(32'h0000_0000);
            if ($urandom_range(0, 3) == 0)
                pool.push_back(32'hFFFF_FFFF);
            for (int n = 0; n < per_phase; n++) begin
                op = ($urandom_range(0, 99) < 45) ? OP_GET : OP_PUT;
                if ($urandom_range(0, 99) < 85) begin
                    // skewed toward low indexes so use counts spread out
                    idx = $urandom_range(0, pool.size() - 1);
                    if ($urandom_range(0, 1) == 0)
                        idx = $urandom_range(0, idx);
                    k = pool[idx];
                end else begin
                    k = $urandom;
                end
                add_access(op, k, $urandom);
                if ($urandom_range(0, 99) < 2)
                    add_drain();
            end
        end

        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;

        wait (step_queue.size() == 0 && items_accepted == items_sent && !start &&
              expected_results.size() == 0);
        repeat (END_SETTLE) @(posedge i_clk);

        $display("tb_top: %0d accesses checked, %0d hits, %0d evictions",
                 results_seen, hits_seen, evictions_seen);
        $display("tb_top: %0d capacity writes incl. 0 and out-of-range, %0d mismatches",
                 cfg_writes, mismatches);
        if (mismatches == 0 && expected_results.size() == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end
endmodule
